/* rtl/core/sse_sp_pkg.sv */
// Shared types and constants for the SSE stream parser core.
// Holds the item and result structs, result kinds, byte codes and the
// controller/datapath command and status structs. No dependencies.
package sse_sp_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_in;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  localparam logic [2:0] KIND_OK   = 3'd0;
  localparam logic [2:0] KIND_ERR  = 3'd1;
  localparam logic [2:0] KIND_NAME = 3'd2;
  localparam logic [2:0] KIND_DATA = 3'd3;
  localparam logic [2:0] KIND_END  = 3'd4;

  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [1:0] FT_NONE   = 2'd0;
  localparam logic [1:0] FT_DATA   = 2'd1;
  localparam logic [1:0] FT_EVENT  = 2'd2;
  localparam logic [1:0] FT_IGNORE = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic [7:0] data_char(logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0: ch = 8'h64;
      2'd1: ch = 8'h61;
      2'd2: ch = 8'h74;
      2'd3: ch = 8'h61;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] event_char(logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h65;
      3'd1:    ch = 8'h76;
      3'd2:    ch = 8'h65;
      3'd3:    ch = 8'h6e;
      3'd4:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_NAME_RD   = 6'b000010,
    ST_NAME_EMIT = 6'b000100,
    ST_DATA_RD   = 6'b001000,
    ST_DATA_EMIT = 6'b010000,
    ST_END_EMIT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic take;
    logic idx_clear;
    logic name_read;
    logic data_read;
    logic emit_name;
    logic emit_data;
    logic emit_end;
  } dp_cmd_t;

  typedef struct packed {
    logic dispatch;
    logic out_free;
    logic name_done;
    logic data_done;
  } dp_status_t;

endpackage

/* rtl/core/sse_stream_parser_core.sv */
// Top level of the SSE stream parser core.
// Joins sse_sp_ctrl and sse_sp_datapath; uses sse_sp_pkg.
//
// Takes one stream byte or finish command per transfer and gives one result
// per item, except at a dispatch, which gives the event name bytes, the data
// bytes without the final newline and an end marker. After an ordinary byte
// the controller stays idle: the next item is taken in the cycle after, as soon
// as the result register is free or being drained. A dispatch with data holds
// off input while the controller reads each buffered byte from RAM and then
// loads it into the result register and then loads the end marker, and longer
// for any stall on the result side. There is no clearing pass after reset.
module sse_stream_parser_core #(
  parameter int DATA_BYTES  = 48,
  parameter int NAME_BYTES  = 16,
  parameter int FIELD_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  sse_sp_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output sse_sp_pkg::result_t result
);

  sse_sp_pkg::dp_cmd_t    cmd;
  sse_sp_pkg::dp_status_t status;
  logic                   busy;

  sse_sp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  sse_sp_datapath #(
    .DATA_BYTES  (DATA_BYTES),
    .NAME_BYTES  (NAME_BYTES),
    .FIELD_BYTES (FIELD_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_last_when_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.last |-> !busy)
    else $error("final result transferred while dispatch still active");

  a_no_take_when_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |-> !busy && (!result_valid || !result_stall) == 1'b0
      || !busy)
    else $error("item transfer during dispatch");

  a_data_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == sse_sp_pkg::KIND_DATA ||
                     result.kind == sse_sp_pkg::KIND_NAME) |-> !result.last)
    else $error("buffered byte marked as final result");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == sse_sp_pkg::KIND_END |-> result.last)
    else $error("end marker not marked as final result");

endmodule

/* rtl/core/sse_sp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the data and event name buffers.
module sse_sp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/sse_sp_ctrl.sv */
// Dispatch controller for the SSE stream parser core.
// Sequences input transfers and event dispatch; uses sse_sp_pkg.
module sse_sp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  sse_sp_pkg::dp_status_t status,
  output sse_sp_pkg::dp_cmd_t    cmd,
  output logic                   busy
);

  sse_sp_pkg::state_t state, state_next;

  assign busy       = (state != sse_sp_pkg::ST_IDLE);
  assign item_stall = busy || !status.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      sse_sp_pkg::ST_IDLE: begin
        if (item_valid && status.out_free) begin
          cmd.take = 1'b1;
          if (status.dispatch) begin
            cmd.idx_clear = 1'b1;
            state_next    = sse_sp_pkg::ST_NAME_RD;
          end
        end
      end
      sse_sp_pkg::ST_NAME_RD: begin
        if (status.name_done) begin
          cmd.idx_clear = 1'b1;
          state_next    = sse_sp_pkg::ST_DATA_RD;
        end else begin
          cmd.name_read = 1'b1;
          state_next    = sse_sp_pkg::ST_NAME_EMIT;
        end
      end
      sse_sp_pkg::ST_NAME_EMIT: begin
        if (status.out_free) begin
          cmd.emit_name = 1'b1;
          state_next    = sse_sp_pkg::ST_NAME_RD;
        end
      end
      sse_sp_pkg::ST_DATA_RD: begin
        if (status.data_done) begin
          state_next = sse_sp_pkg::ST_END_EMIT;
        end else begin
          cmd.data_read = 1'b1;
          state_next    = sse_sp_pkg::ST_DATA_EMIT;
        end
      end
      sse_sp_pkg::ST_DATA_EMIT: begin
        if (status.out_free) begin
          cmd.emit_data = 1'b1;
          state_next    = sse_sp_pkg::ST_DATA_RD;
        end
      end
      sse_sp_pkg::ST_END_EMIT: begin
        if (status.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = sse_sp_pkg::ST_IDLE;
        end
      end
      default: state_next = sse_sp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sse_sp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/sse_sp_datapath.sv */
// Datapath of the SSE stream parser core: line state, field decode,
// data and name buffers, dispatch index and result register.
// Uses sse_sp_pkg and sse_sp_ram.
module sse_sp_datapath #(
  parameter int DATA_BYTES  = 48,
  parameter int NAME_BYTES  = 16,
  parameter int FIELD_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sse_sp_pkg::item_t      item,
  input  sse_sp_pkg::dp_cmd_t    cmd,
  output sse_sp_pkg::dp_status_t status,
  output logic                   result_valid,
  input  logic                   result_stall,
  output sse_sp_pkg::result_t    result
);

  localparam int DCW        = $clog2(DATA_BYTES + 1);
  localparam int DAW        = $clog2(DATA_BYTES);
  localparam int NAME_DEPTH = NAME_BYTES - 1;
  localparam int NCW        = $clog2(NAME_BYTES);
  localparam int NAW        = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
  localparam int FCW        = $clog2(FIELD_BYTES);
  localparam int IW         = (DCW > NCW) ? DCW : NCW;

  logic [DCW-1:0] data_count, data_count_next;
  logic [NCW-1:0] name_count, name_count_next;
  logic [FCW-1:0] field_count, field_count_next;
  logic [1:0]     field_type, field_type_next;
  logic           field_done, field_done_next;
  logic           skip_space, skip_space_next;
  logic           line_used, line_used_next;
  logic           line_data_seen, line_data_seen_next;
  logic           last_nl, last_nl_next;
  logic           match_data, match_data_next;
  logic           match_event, match_event_next;
  logic [IW-1:0]  rd_idx;
  logic [NCW-1:0] name_len;
  logic [DCW-1:0] data_out_len, data_out_len_next;
  sse_sp_pkg::result_t out_data;
  logic           out_valid;

  logic           data_we, name_we, dispatch, do_close, do_send, data_full;
  logic [7:0]     data_wdata;
  logic [2:0]     kind;
  logic [7:0]     data_rd, name_rd;
  logic [7:0]     ch;
  logic           out_free, out_load;
  sse_sp_pkg::result_t out_next;

  assign ch        = item.byte_in;
  assign data_full = (data_count == DCW'(DATA_BYTES));
  assign out_free  = !out_valid || !result_stall;

  always_comb begin
    data_count_next     = data_count;
    name_count_next     = name_count;
    field_count_next    = field_count;
    field_type_next     = field_type;
    field_done_next     = field_done;
    skip_space_next     = skip_space;
    line_used_next      = line_used;
    line_data_seen_next = line_data_seen;
    last_nl_next        = last_nl;
    match_data_next     = match_data;
    match_event_next    = match_event;
    data_out_len_next   = data_count - DCW'(last_nl);
    data_we             = 1'b0;
    data_wdata          = ch;
    name_we             = 1'b0;
    dispatch            = 1'b0;
    do_close            = 1'b0;
    do_send             = 1'b0;
    kind                = sse_sp_pkg::KIND_OK;

    if (item.command == sse_sp_pkg::CMD_FINISH) begin
      if (line_used && line_data_seen && data_full) begin
        kind = sse_sp_pkg::KIND_ERR;
      end else begin
        do_close = line_used;
        do_send  = 1'b1;
      end
    end else if (ch == sse_sp_pkg::CH_CR) begin
      kind = sse_sp_pkg::KIND_OK;
    end else if (ch == sse_sp_pkg::CH_LF) begin
      if (!line_used) begin
        do_send = 1'b1;
      end else if (line_data_seen && data_full) begin
        kind = sse_sp_pkg::KIND_ERR;
      end else begin
        do_close = 1'b1;
      end
    end else begin
      line_used_next = 1'b1;
      if (!field_done) begin
        if (ch == sse_sp_pkg::CH_COLON) begin
          field_done_next = 1'b1;
          if (field_count == '0) begin
            field_type_next = sse_sp_pkg::FT_IGNORE;
          end else begin
            skip_space_next = 1'b1;
            if (field_count == FCW'(4) && match_data) begin
              field_type_next = sse_sp_pkg::FT_DATA;
            end else if (field_count == FCW'(5) && match_event) begin
              field_type_next = sse_sp_pkg::FT_EVENT;
            end else begin
              field_type_next = sse_sp_pkg::FT_IGNORE;
            end
          end
        end else if (field_count >= FCW'(FIELD_BYTES - 1)) begin
          field_type_next = sse_sp_pkg::FT_IGNORE;
          field_done_next = 1'b1;
        end else begin
          field_count_next = field_count + FCW'(1);
          match_data_next  = match_data && (field_count < FCW'(4)) &&
                             (ch == sse_sp_pkg::data_char(field_count[1:0]));
          match_event_next = match_event && (field_count < FCW'(5)) &&
                             (ch == sse_sp_pkg::event_char(field_count[2:0]));
        end
      end else if (skip_space && ch == sse_sp_pkg::CH_SPACE) begin
        skip_space_next = 1'b0;
      end else begin
        skip_space_next = 1'b0;
        if (field_type == sse_sp_pkg::FT_DATA) begin
          if (data_full) begin
            kind = sse_sp_pkg::KIND_ERR;
          end else begin
            data_we             = 1'b1;
            data_count_next     = data_count + DCW'(1);
            line_data_seen_next = 1'b1;
            last_nl_next        = 1'b0;
          end
        end else if (field_type == sse_sp_pkg::FT_EVENT) begin
          if (name_count != NCW'(NAME_BYTES - 1)) begin
            name_we         = 1'b1;
            name_count_next = name_count + NCW'(1);
          end
        end
      end
    end

    if (do_close) begin
      if (line_data_seen) begin
        data_we           = 1'b1;
        data_wdata        = sse_sp_pkg::CH_LF;
        data_count_next   = data_count + DCW'(1);
        last_nl_next      = 1'b1;
        data_out_len_next = data_count;
      end
      field_count_next    = '0;
      field_type_next     = sse_sp_pkg::FT_NONE;
      field_done_next     = 1'b0;
      skip_space_next     = 1'b0;
      line_used_next      = 1'b0;
      line_data_seen_next = 1'b0;
      match_data_next     = 1'b1;
      match_event_next    = 1'b1;
    end

    if (do_send) begin
      name_count_next = '0;
      if (data_count != '0) begin
        dispatch        = 1'b1;
        data_count_next = '0;
        last_nl_next    = 1'b0;
      end
    end
  end

  assign status.dispatch  = dispatch;
  assign status.out_free  = out_free;
  assign status.name_done = (rd_idx == IW'(name_len));
  assign status.data_done = (rd_idx == IW'(data_out_len));

  sse_sp_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_data_ram (
    .clk     (clk),
    .wr_en   (cmd.take && data_we),
    .wr_addr (data_count[DAW-1:0]),
    .wr_data (data_wdata),
    .rd_en   (cmd.data_read),
    .rd_addr (rd_idx[DAW-1:0]),
    .rd_data (data_rd)
  );

  sse_sp_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name_ram (
    .clk     (clk),
    .wr_en   (cmd.take && name_we),
    .wr_addr (name_count[NAW-1:0]),
    .wr_data (ch),
    .rd_en   (cmd.name_read),
    .rd_addr (rd_idx[NAW-1:0]),
    .rd_data (name_rd)
  );

  always_comb begin
    out_load = 1'b0;
    out_next = '{kind: sse_sp_pkg::KIND_OK, value: 8'h00, last: 1'b1};
    if (cmd.take && !dispatch) begin
      out_load      = 1'b1;
      out_next.kind = kind;
    end else if (cmd.emit_name) begin
      out_load = 1'b1;
      out_next = '{kind: sse_sp_pkg::KIND_NAME, value: name_rd, last: 1'b0};
    end else if (cmd.emit_data) begin
      out_load = 1'b1;
      out_next = '{kind: sse_sp_pkg::KIND_DATA, value: data_rd, last: 1'b0};
    end else if (cmd.emit_end) begin
      out_load      = 1'b1;
      out_next.kind = sse_sp_pkg::KIND_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_count     <= '0;
      name_count     <= '0;
      field_count    <= '0;
      field_type     <= sse_sp_pkg::FT_NONE;
      field_done     <= 1'b0;
      skip_space     <= 1'b0;
      line_used      <= 1'b0;
      line_data_seen <= 1'b0;
      last_nl        <= 1'b0;
      match_data     <= 1'b1;
      match_event    <= 1'b1;
      rd_idx         <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.take) begin
        data_count     <= data_count_next;
        name_count     <= name_count_next;
        field_count    <= field_count_next;
        field_type     <= field_type_next;
        field_done     <= field_done_next;
        skip_space     <= skip_space_next;
        line_used      <= line_used_next;
        line_data_seen <= line_data_seen_next;
        last_nl        <= last_nl_next;
        match_data     <= match_data_next;
        match_event    <= match_event_next;
      end
      if (cmd.idx_clear) begin
        rd_idx <= '0;
      end else if (cmd.emit_name || cmd.emit_data) begin
        rd_idx <= rd_idx + IW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && dispatch) begin
      name_len     <= name_count;
      data_out_len <= data_out_len_next;
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  assign result_valid = out_valid;
  assign result       = out_data;

endmodule
